// File: hdl/text_command_recognizer_assert.svh
// Assertion macros shared by the command recognizer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TEXT_COMMAND_RECOGNIZER_ASSERT_SVH
`define TEXT_COMMAND_RECOGNIZER_ASSERT_SVH

// Property that must hold at every rising clock edge outside reset.
`define TCR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define TCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `TCR_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// File: hdl/tcr_pkg.sv
// Types, keyword tables and result structures of the command recognizer.
// Depends on nothing; used by the comparator, line state, top level and test files.
package tcr_pkg;

  localparam int KW_NUM     = 9;
  localparam int KW_MAX_LEN = 8;

  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef logic [KW_NUM-1:0]             kw_mask_t;
  typedef logic [$clog2(KW_MAX_LEN)-1:0] kw_pos_t;
  typedef logic [$clog2(KW_MAX_LEN+1)-1:0] kw_len_t;

  typedef enum logic [2:0] {
    CMD_UNKNOWN     = 3'd0,
    CMD_SET_FORMAT  = 3'd1,
    CMD_MEASURE     = 3'd2,
    CMD_STREAM_ON   = 3'd3,
    CMD_STREAM_OFF  = 3'd4,
    CMD_WRITE_ITIME = 3'd5,
    CMD_READ_ITIME  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    PH_MATCH,
    PH_SPACE,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  // Keywords in priority order; unused tail characters are zero.
  localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAX_LEN] = '{
    '{"f", "o", "r", "m", "a", "t", "=", 8'h00},
    '{"m", "e", "a", "s", "u", "r", "e", CHAR_CR},
    '{"m", CHAR_CR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", "e", "a", "m", CHAR_CR, 8'h00},
    '{"e", "n", "d", CHAR_CR, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "t", "i", "m", "e", "=", 8'h00, 8'h00},
    '{"i", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "t", "i", "m", "e", "?", CHAR_CR, 8'h00},
    '{"i", "?", CHAR_CR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam kw_len_t KW_LEN [KW_NUM] = '{
    kw_len_t'(7), kw_len_t'(8), kw_len_t'(2), kw_len_t'(7), kw_len_t'(4),
    kw_len_t'(6), kw_len_t'(2), kw_len_t'(7), kw_len_t'(3)
  };

  localparam cmd_e KW_CMD [KW_NUM] = '{
    CMD_SET_FORMAT, CMD_MEASURE, CMD_MEASURE, CMD_STREAM_ON, CMD_STREAM_OFF,
    CMD_WRITE_ITIME, CMD_WRITE_ITIME, CMD_READ_ITIME, CMD_READ_ITIME
  };

  localparam logic KW_VALUE [KW_NUM] = '{
    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0
  };

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } item_t;

  typedef struct packed {
    kw_mask_t mask;
    logic     hit;
    cmd_e     cmd;
    logic     needs_value;
  } match_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] value;
    logic        updated;
  } result_t;

endpackage

// File: hdl/tcr_in_if.sv
// Input channel of the command recognizer: one line character per transfer.
// Depends on nothing.
interface tcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

// File: hdl/tcr_out_if.sv
// Output channel of the command recognizer: one decoded command per transfer.
// Depends on nothing.
interface tcr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] value;
  logic        value_updated;

  modport source (output valid, output command, output value, output value_updated,
                  input ready);
  modport sink   (input valid, input command, input value, input value_updated,
                  output ready);
endinterface

// File: hdl/tcr_kw_match.sv
// Keyword comparator: checks one character against every live keyword.
// Depends on tcr_pkg.
module tcr_kw_match (
  input  tcr_pkg::kw_pos_t  pos_i,
  input  tcr_pkg::kw_mask_t mask_i,
  input  logic [7:0]        byte_i,
  output tcr_pkg::match_t   match_o
);

  tcr_pkg::kw_len_t pos_ext;
  tcr_pkg::kw_len_t pos_next;

  assign pos_ext  = tcr_pkg::kw_len_t'(pos_i);
  assign pos_next = pos_ext + tcr_pkg::kw_len_t'(1);

  always_comb begin
    match_o = '0;
    match_o.cmd = tcr_pkg::CMD_UNKNOWN;
    for (int c = 0; c < tcr_pkg::KW_NUM; c++) begin
      match_o.mask[c] = mask_i[c] && (pos_ext < tcr_pkg::KW_LEN[c]) &&
                        (tcr_pkg::KW_TEXT[c][pos_i] == byte_i);
    end
    // Walk downward so that the earliest keyword in priority order wins.
    for (int c = tcr_pkg::KW_NUM - 1; c >= 0; c--) begin
      if (match_o.mask[c] && (tcr_pkg::KW_LEN[c] == pos_next)) begin
        match_o.hit         = 1'b1;
        match_o.cmd         = tcr_pkg::KW_CMD[c];
        match_o.needs_value = tcr_pkg::KW_VALUE[c];
      end
    end
  end

endmodule

// File: hdl/tcr_line_fsm.sv
// Line state of the recognizer: keyword phase, number parser, held value.
// Depends on tcr_pkg and tcr_kw_match.
module tcr_line_fsm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  tcr_pkg::item_t   item_i,
  output tcr_pkg::result_t result_o
);

  tcr_pkg::phase_e   phase_q, phase_d, cur_phase;
  tcr_pkg::kw_pos_t  pos_q, pos_d, cur_pos;
  tcr_pkg::kw_mask_t mask_q, mask_d, cur_mask;
  logic [31:0]       acc_q, acc_d, cur_acc;
  logic              seen_q, seen_d, cur_seen;
  logic              neg_q, neg_d, cur_neg;
  logic              ovf_q, ovf_d, cur_ovf;
  tcr_pkg::cmd_e     cmd_q, cmd_d, cur_cmd;
  logic [31:0]       held_q, held_d;

  tcr_pkg::match_t   kw;
  logic              is_digit, is_space, is_sign, commit;
  logic [3:0]        digit;
  logic [35:0]       prod;

  assign is_digit = (item_i.data >= "0") && (item_i.data <= "9");
  assign is_space = (item_i.data == " ") || ((item_i.data >= 8'h09) && (item_i.data <= 8'h0D));
  assign is_sign  = (item_i.data == "+") || (item_i.data == "-");
  assign digit    = 4'(item_i.data - "0");
  // Times ten as two shifts plus the new digit.
  assign prod = ({4'b0, cur_acc} << 3) + ({4'b0, cur_acc} << 1) + {32'b0, digit};

  tcr_kw_match u_kw_match (
    .pos_i   (cur_pos),
    .mask_i  (cur_mask),
    .byte_i  (item_i.data),
    .match_o (kw)
  );

  // A marked first character restarts the line before it is handled.
  always_comb begin
    if (item_i.first) begin
      cur_phase = tcr_pkg::PH_MATCH;
      cur_pos   = '0;
      cur_mask  = '1;
      cur_acc   = '0;
      cur_seen  = 1'b0;
      cur_neg   = 1'b0;
      cur_ovf   = 1'b0;
      cur_cmd   = tcr_pkg::CMD_UNKNOWN;
    end else begin
      cur_phase = phase_q;
      cur_pos   = pos_q;
      cur_mask  = mask_q;
      cur_acc   = acc_q;
      cur_seen  = seen_q;
      cur_neg   = neg_q;
      cur_ovf   = ovf_q;
      cur_cmd   = cmd_q;
    end
  end

  always_comb begin
    phase_d = cur_phase;
    pos_d   = cur_pos;
    mask_d  = cur_mask;
    acc_d   = cur_acc;
    seen_d  = cur_seen;
    neg_d   = cur_neg;
    ovf_d   = cur_ovf;
    cmd_d   = cur_cmd;
    commit  = 1'b0;
    unique case (cur_phase)
      tcr_pkg::PH_MATCH: begin
        mask_d = kw.mask;
        if (kw.hit) begin
          cmd_d   = kw.cmd;
          phase_d = kw.needs_value ? tcr_pkg::PH_SPACE : tcr_pkg::PH_DONE;
        end else if (kw.mask == '0) begin
          phase_d = tcr_pkg::PH_DONE;
        end else if (cur_pos != '1) begin
          pos_d = cur_pos + 1'b1;
        end
      end
      tcr_pkg::PH_SPACE: begin
        if (is_space) begin
          phase_d = tcr_pkg::PH_SPACE;
        end else if (is_sign) begin
          neg_d   = (item_i.data == "-");
          phase_d = tcr_pkg::PH_DIGITS;
        end else if (is_digit) begin
          seen_d  = 1'b1;
          ovf_d   = cur_ovf | (prod[35:32] != '0);
          acc_d   = (prod[35:32] != '0) ? '1 : prod[31:0];
          phase_d = tcr_pkg::PH_DIGITS;
        end else begin
          phase_d = tcr_pkg::PH_DONE;
        end
      end
      tcr_pkg::PH_DIGITS: begin
        if (is_digit) begin
          seen_d = 1'b1;
          ovf_d  = cur_ovf | (prod[35:32] != '0);
          acc_d  = (prod[35:32] != '0) ? '1 : prod[31:0];
        end else begin
          commit  = 1'b1;
          phase_d = tcr_pkg::PH_DONE;
        end
      end
      tcr_pkg::PH_DONE: begin
        phase_d = tcr_pkg::PH_DONE;
      end
    endcase
    // A line end closes a number that is still open.
    if (item_i.last && ((phase_d == tcr_pkg::PH_SPACE) || (phase_d == tcr_pkg::PH_DIGITS))) begin
      commit = 1'b1;
    end
    if (commit && seen_d) begin
      held_d = ovf_d ? '1 : (neg_d ? (32'd0 - acc_d) : acc_d);
    end else begin
      held_d = held_q;
    end
    result_o.cmd     = cmd_d;
    result_o.value   = held_d;
    result_o.updated = seen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tcr_pkg::PH_MATCH;
      pos_q   <= '0;
      mask_q  <= '1;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      cmd_q   <= tcr_pkg::CMD_UNKNOWN;
      held_q  <= '0;
    end else if (step_i) begin
      held_q <= held_d;
      if (item_i.last) begin
        phase_q <= tcr_pkg::PH_MATCH;
        pos_q   <= '0;
        mask_q  <= '1;
        acc_q   <= '0;
        seen_q  <= 1'b0;
        neg_q   <= 1'b0;
        ovf_q   <= 1'b0;
        cmd_q   <= tcr_pkg::CMD_UNKNOWN;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        mask_q  <= mask_d;
        acc_q   <= acc_d;
        seen_q  <= seen_d;
        neg_q   <= neg_d;
        ovf_q   <= ovf_d;
        cmd_q   <= cmd_d;
      end
    end
  end

endmodule

// File: hdl/text_command_recognizer.sv
// Text command recognizer, top level: input register, line state, result register.
// Path: a line's last character is taken into the input register, handled by the line
// state once the result register has room, and its result is shown from the result register.
// Throughput: one character per cycle; only a last character waits while a result is unread.
// Reset (rst_ni low, asynchronous) empties both registers, restarts the line and clears
// the held value to zero.
`include "text_command_recognizer_assert.svh"

module text_command_recognizer (
  input  logic     clk_i,
  input  logic     rst_ni,
  tcr_in_if.sink   in_i,
  tcr_out_if.source out_o
);

  // Input register. Every character passes through it; it parts the sender from
  // the line state so that ready does not depend on the keyword compare.
  logic             in_vld_q;
  tcr_pkg::item_t   item_q;

  // Result register. It holds a finished command until the receiver takes it,
  // while further characters of the next line keep flowing behind it.
  logic             out_vld_q;
  tcr_pkg::result_t res_q;
  tcr_pkg::result_t res_d;

  logic             adv;
  logic             out_free;

  // The result register has room when it is empty or being emptied this cycle.
  assign out_free = !out_vld_q || out_o.ready;

  // A character advances unless it ends a line and the previous result is
  // still waiting. Characters inside a line never wait.
  assign adv = in_vld_q && (!item_q.last || out_free);

  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.data  <= in_i.data_byte;
      item_q.first <= in_i.first_byte;
      item_q.last  <= in_i.last_byte;
    end
  end

  // Keyword matching, number parsing and the held value all live here; the
  // state moves by one character each time adv is high.
  tcr_line_fsm u_line_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .item_i   (item_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && item_q.last) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && item_q.last) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.command       = res_q.cmd;
  assign out_o.value         = res_q.value;
  assign out_o.value_updated = res_q.updated;

  // A line end that advances always produces a pending result.
  `TCR_ASSERT_NEXT(a_line_end_loads, clk_i, rst_ni, adv && item_q.last, out_vld_q, "line end lost its result")
  // The result register changes only when a line ends.
  `TCR_ASSERT_NEXT(a_result_only_on_end, clk_i, rst_ni, !(adv && item_q.last), $stable(res_q), "result changed mid line")
  // A character that cannot advance keeps its place in the input register.
  `TCR_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, in_vld_q && !adv, in_vld_q && $stable(item_q), "stalled character lost")
  // The sender is held off only behind a line end waiting on an unread result.
  `TCR_ASSERT(a_ready_cause, clk_i, rst_ni, !in_i.ready |-> (in_vld_q && item_q.last && out_vld_q), "ready dropped without cause")

endmodule

// File: sim/tcr_checker.sv
// Scoreboard for the text command recognizer: watches both channels, decodes every
// accepted character itself and compares each command transfer with its own forecast.
// Depends on tcr_pkg, tcr_in_if and tcr_out_if.
`timescale 1ns / 1ps

module tcr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcr_in_if           in_mon,
  tcr_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Line decoder state, kept apart from the block.
  tcr_pkg::phase_e   line_phase;
  tcr_pkg::kw_pos_t  kw_pos;
  tcr_pkg::kw_mask_t alive;
  logic [31:0]       number_acc;
  logic              saw_digit;
  logic              minus;
  logic              saturated;
  logic [31:0]       held_value;
  tcr_pkg::cmd_e     line_cmd;

  tcr_pkg::result_t  commands_due[$];
  int unsigned       mismatches;

  task automatic restart_line();
    line_phase = tcr_pkg::PH_MATCH;
    kw_pos     = '0;
    alive      = '1;
    number_acc = '0;
    saw_digit  = 1'b0;
    minus      = 1'b0;
    saturated  = 1'b0;
    line_cmd   = tcr_pkg::CMD_UNKNOWN;
  endtask

  task automatic add_digit(input logic [7:0] ch);
    logic [35:0] nxt;
    nxt       = {4'b0, number_acc} * 36'd10 + 36'(ch - 8'h30);
    saw_digit = 1'b1;
    if (nxt > 36'hFFFF_FFFF) begin
      saturated  = 1'b1;
      number_acc = 32'hFFFF_FFFF;
    end else begin
      number_acc = nxt[31:0];
    end
  endtask

  task automatic commit_number();
    if (saw_digit) begin
      if (saturated) held_value = 32'hFFFF_FFFF;
      else if (minus) held_value = 32'd0 - number_acc;
      else held_value = number_acc;
    end
    line_phase = tcr_pkg::PH_DONE;
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic first, input logic last);
    bit               found;
    tcr_pkg::result_t res;
    found = 1'b0;
    if (first) restart_line();
    case (line_phase)
      tcr_pkg::PH_MATCH: begin
        for (int c = 0; c < tcr_pkg::KW_NUM; c++) begin
          if (alive[c] && ({1'b0, kw_pos} >= tcr_pkg::KW_LEN[c] ||
                           tcr_pkg::KW_TEXT[c][kw_pos] != ch))
            alive[c] = 1'b0;
        end
        // The first complete keyword in priority order wins.
        for (int c = 0; c < tcr_pkg::KW_NUM; c++) begin
          if (!found && alive[c] && tcr_pkg::KW_LEN[c] == kw_pos + 1) begin
            found      = 1'b1;
            line_cmd   = tcr_pkg::KW_CMD[c];
            line_phase = tcr_pkg::KW_VALUE[c] ? tcr_pkg::PH_SPACE : tcr_pkg::PH_DONE;
          end
        end
        if (!found) begin
          if (alive == '0) line_phase = tcr_pkg::PH_DONE;
          else if (kw_pos < 3'd7) kw_pos = kw_pos + 3'd1;
        end
      end
      tcr_pkg::PH_SPACE: begin
        if (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D)) begin
          line_phase = tcr_pkg::PH_SPACE;
        end else if (ch == "+" || ch == "-") begin
          minus      = (ch == "-");
          line_phase = tcr_pkg::PH_DIGITS;
        end else if (ch >= "0" && ch <= "9") begin
          add_digit(ch);
          line_phase = tcr_pkg::PH_DIGITS;
        end else begin
          line_phase = tcr_pkg::PH_DONE;
        end
      end
      tcr_pkg::PH_DIGITS: begin
        if (ch >= "0" && ch <= "9") add_digit(ch);
        else commit_number();
      end
      default: ;
    endcase
    if (last) begin
      if (line_phase == tcr_pkg::PH_SPACE || line_phase == tcr_pkg::PH_DIGITS)
        commit_number();
      res.cmd     = line_cmd;
      res.value   = held_value;
      res.updated = saw_digit;
      commands_due.push_back(res);
      restart_line();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tcr_pkg::result_t want;
    if (!rst_ni) begin
      restart_line();
      held_value = '0;
      commands_due.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        decode_char(in_mon.data_byte, in_mon.first_byte, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready) begin
        if (commands_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: command transfer without a finished line: cmd %0d value %0d upd %b",
                     $realtime, out_mon.command, out_mon.value, out_mon.value_updated);
          mismatches++;
        end else begin
          want = commands_due.pop_front();
          if (out_mon.command !== want.cmd || out_mon.value !== want.value ||
              out_mon.value_updated !== want.updated) begin
            if (mismatches < 10)
              $display("%0t: wrong command: want cmd %0d value %0d upd %b, got %0d %0d %b",
                       $realtime, want.cmd, want.value, want.updated,
                       out_mon.command, out_mon.value, out_mon.value_updated);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= commands_due.size();
    end
  end

endmodule

// File: sim/tb_text_command_recognizer.sv
// Testbench top for the text command recognizer: clock, reset, character stimulus,
// command-side back-pressure, watchdog and verdict. Checking sits in tcr_checker.
// Depends on tcr_pkg, tcr_in_if, tcr_out_if, tcr_checker and the block itself.
`timescale 1ns / 1ps

module tb_text_command_recognizer;

  // Cycles without any transfer on either side before the run is given up.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Length of the long receiver hold-off that fills the block up.
  localparam int          HOLD_CYCLES = 80;
  // Characters per random phase.
  localparam int unsigned PHASE_CHARS = 110;
  // Settling time after the last expected command.
  localparam int          TAIL_CYCLES = 8;

  typedef logic [7:0] char_q_t[$];

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int          gap_pct     = 0;
  int          stall_pct   = 0;
  bit          hold_req    = 1'b0;
  bit          hold_ack    = 1'b0;
  int          hold_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned chars_sent  = 0;

  tcr_in_if  in_ch ();
  tcr_out_if out_ch ();

  text_command_recognizer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  tcr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Command side. A toggle of hold_req starts a long hold-off that this process
  // counts down on its own; otherwise ready stalls at random by stall_pct.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one character, with random idle cycles in front of it by gap_pct, and
  // returns at the edge where the transfer happens. Valid stays high afterwards, so
  // the caller either offers the next character at once or lowers valid itself.
  task automatic send_char(input logic [7:0] ch, input logic first, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= ch;
    in_ch.first_byte <= first;
    in_ch.last_byte  <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    chars_sent++;
  endtask

  // Sends a whole line. The first character carries the line start mark when asked;
  // with scatter set, later characters may carry it too, which restarts the line.
  task automatic send_line(input char_q_t line, input bit mark_first, input bit scatter,
                           input bit end_line);
    foreach (line[i])
      send_char(line[i], (i == 0 && mark_first) || (scatter && i != 0 && $urandom_range(3) == 0),
                end_line && i == line.size() - 1);
  endtask

  function automatic char_q_t text_chars(input string s, input bit with_cr);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    if (with_cr) q.push_back(tcr_pkg::CHAR_CR);
    return q;
  endfunction

  // Lowers valid and waits until every finished line has produced its command. The
  // pending count is registered in the checker, so it is read after its register has updated.
  task automatic wait_for_commands();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    char_q_t     line;
    bit          mark_first;
    bit          scatter;
    bit          end_line;
    int          kind;
    int          kw;
    int          pick;
    string       digits;
    int unsigned target;

    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte  = 1'b0;
    rst_ni           = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines. The short measure form, then the stream end keyword without a
    // start mark (the line restarts by itself after a command), the short itime read,
    // a negative value that wraps, a value field with junk instead of digits, lines
    // made of a single extreme character, and a line cut off inside a keyword.
    send_line(text_chars("m", 1'b1), 1'b1, 1'b0, 1'b1);
    send_line(text_chars("end", 1'b1), 1'b0, 1'b0, 1'b1);
    send_line(text_chars("i?", 1'b1), 1'b1, 1'b0, 1'b1);
    send_line(text_chars("i=-12", 1'b0), 1'b1, 1'b0, 1'b1);
    send_line(text_chars("i= x", 1'b0), 1'b1, 1'b0, 1'b1);
    send_char(8'hFF, 1'b1, 1'b1);
    send_char(8'h00, 1'b1, 1'b1);
    send_line(text_chars("fo", 1'b0), 1'b1, 1'b0, 1'b1);
    wait_for_commands();

    // Random phases: no idling, a mostly idle sender, a mostly stalling receiver,
    // and both idling a little. Each phase ends with the sender pausing until every
    // command has come out.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 86; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 86; end
        default: begin gap_pct = 28; stall_pct <= 28; end
      endcase
      // In the phase without idling, the receiver holds off for a long stretch while
      // lines keep coming, so a second finished line has to wait at the input.
      if (ph == 0) hold_req <= ~hold_req;
      target = chars_sent + PHASE_CHARS;
      while (chars_sent < target) begin
        line.delete();
        kind       = $urandom_range(99);
        kw         = $urandom_range(tcr_pkg::KW_NUM - 1);
        mark_first = ($urandom_range(3) != 0);
        scatter    = 1'b0;
        end_line   = 1'b1;
        if (kind < 70) begin
          // Well-formed command, possibly with a value and with junk behind it.
          for (int i = 0; i < tcr_pkg::KW_LEN[kw]; i++)
            line.push_back(tcr_pkg::KW_TEXT[kw][i]);
          if (tcr_pkg::KW_VALUE[kw]) begin
            repeat ($urandom_range(1) * $urandom_range(3)) begin
              pick = $urandom_range(8, 13);
              line.push_back(pick == 8 ? 8'h20 : 8'(pick));
            end
            pick = $urandom_range(9);
            if (pick >= 8) line.push_back("-");
            else if (pick >= 6) line.push_back("+");
            pick = $urandom_range(9);
            case (pick)
              0:       digits = "";
              1, 2, 3, 4: digits = $sformatf("%0d", $urandom_range(999));
              5, 6:    digits = $sformatf("%0d", $urandom());
              7:       digits = "4294967295";
              8:       digits = $sformatf("%0d", 64'd4294967296 + $urandom_range(5));
              default: digits = "";
            endcase
            if (digits.len() != 0 && $urandom_range(3) == 0)
              repeat ($urandom_range(1, 3)) line.push_back("0");
            for (int i = 0; i < digits.len(); i++) line.push_back(digits[i]);
            // Long digit strings, which saturate unless leading zeros keep them in range.
            if (pick == 9)
              repeat ($urandom_range(11, 13)) line.push_back(8'($urandom_range(48, 57)));
          end
          if ($urandom_range(2) == 0)
            repeat ($urandom_range(1, 3)) line.push_back(8'($urandom_range(255)));
        end else if (kind < 85) begin
          // Line that ends inside a keyword.
          pick = $urandom_range(1, tcr_pkg::KW_LEN[kw] - 1);
          for (int i = 0; i < pick; i++) line.push_back(tcr_pkg::KW_TEXT[kw][i]);
        end else begin
          // Noise with stray line starts, sometimes left open for the next line.
          repeat ($urandom_range(1, 6)) line.push_back(8'($urandom_range(255)));
          scatter  = 1'b1;
          end_line = $urandom_range(1);
        end
        send_line(line, mark_first, scatter, end_line);
      end
      wait_for_commands();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
